// ----- rtl/ccp_pkg.sv -----
// shared widths, constants and stage types for the circumcircle pipeline
// no dependencies
package ccp_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIF_W      = COORD_BITS + 1;        // point differences
  localparam int D_W        = 2 * DIF_W + 2;         // denominator, signed
  localparam int SQ_W       = 2 * DIF_W;             // squared lengths
  localparam int N_W        = DIF_W + SQ_W + 2;      // numerators nx, ny, signed
  localparam int NUM_W      = N_W + 1;               // a*d + n, signed
  localparam int HALF_W     = (N_W + 1) / 2;         // low half for squaring
  localparam int HI_W       = N_W - HALF_W;
  localparam int FRAC_BITS  = 8;
  localparam int RAD_FRAC   = 2 * FRAC_BITS;
  localparam int ROOT_W     = (2 * N_W + 1 + RAD_FRAC + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DVD_W      = ROOT_W;
  localparam int OUT_W      = 32;
  localparam int NLANE      = 3;

  localparam int LN_X = 0;
  localparam int LN_Y = 1;
  localparam int LN_R = 2;

  localparam logic [OUT_W-1:0] CTR_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] CTR_MIN = 32'h8000_0000;
  localparam logic [OUT_W-1:0] RAD_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } pt_t;

  typedef struct packed {
    logic             v;
    logic             dz;
    logic             sx;
    logic             sy;
    logic [NUM_W-1:0] mnx;
    logic [NUM_W-1:0] mny;
    logic [D_W-1:0]   dmag;
    logic [RAD_W-1:0] rad;
  } fr_t;

  typedef struct packed {
    logic              v;
    logic              dz;
    logic              sx;
    logic              sy;
    logic [NUM_W-1:0]  mnx;
    logic [NUM_W-1:0]  mny;
    logic [D_W-1:0]    dmag;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                        v;
    logic                        dz;
    logic                        sx;
    logic                        sy;
    logic [NLANE-1:0][DVD_W-1:0] q;
  } dv_t;

endpackage

// ----- rtl/ccp_if.sv -----
// valid/ready channels for point triples and circle results
// depends on ccp_pkg
interface ccp_pt_if import ccp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface ccp_cc_if import ccp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    valid_res;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic        [OUT_W-1:0] radius;
  modport source (output valid, valid_res, center_x, center_y, radius, input ready);
  modport sink (input valid, valid_res, center_x, center_y, radius, output ready);
endinterface

// ----- rtl/ccp_front.sv -----
// front end: differences, denominator, numerators and the squared radius term
// depends on ccp_pkg
module ccp_front import ccp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic v_i,
  input  pt_t  pt_i,
  output fr_t  fr_o
);

  logic [5:0] v_q;

  // stage 1
  logic signed [COORD_BITS-1:0] ax1_q, ay1_q;
  logic signed [DIF_W-1:0] bxr1_q, byr1_q, cxr1_q, cyr1_q;
  // stage 2
  logic signed [COORD_BITS-1:0] ax2_q, ay2_q;
  logic signed [DIF_W-1:0] bxr2_q, byr2_q, cxr2_q, cyr2_q;
  logic signed [D_W-1:0] d2_q;
  logic signed [SQ_W:0] b2_q, c2_q;
  // stage 3
  logic signed [N_W-1:0] nx3_q, ny3_q;
  logic signed [NUM_W-1:0] adx3_q, ady3_q;
  logic signed [D_W-1:0] d3_q;
  // stage 4
  logic signed [NUM_W-1:0] numx4_q, numy4_q;
  logic [N_W-1:0] mx4_q, my4_q;
  logic [D_W-1:0] dmag4_q;
  logic sd4_q, dz4_q;
  // stage 5
  logic [NUM_W-1:0] mnx5_q, mny5_q;
  logic [2*HALF_W-1:0] xll5_q, yll5_q;
  logic [HALF_W+HI_W-1:0] xlh5_q, ylh5_q;
  logic [2*HI_W-1:0] xhh5_q, yhh5_q;
  logic [D_W-1:0] dmag5_q;
  logic sx5_q, sy5_q, dz5_q;
  // stage 6
  logic [NUM_W-1:0] mnx6_q, mny6_q;
  logic [D_W-1:0] dmag6_q;
  logic sx6_q, sy6_q, dz6_q;
  logic [RAD_W-1:0] rad6_q;

  logic [HALF_W-1:0] xlo, ylo;
  logic [HI_W-1:0] xhi, yhi;

  assign xlo = mx4_q[HALF_W-1:0];
  assign xhi = mx4_q[N_W-1:HALF_W];
  assign ylo = my4_q[HALF_W-1:0];
  assign yhi = my4_q[N_W-1:HALF_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= pt_i.ax;
      ay1_q  <= pt_i.ay;
      bxr1_q <= DIF_W'(pt_i.bx) - DIF_W'(pt_i.ax);
      byr1_q <= DIF_W'(pt_i.by_coord) - DIF_W'(pt_i.ay);
      cxr1_q <= DIF_W'(pt_i.cx) - DIF_W'(pt_i.ax);
      cyr1_q <= DIF_W'(pt_i.cy) - DIF_W'(pt_i.ay);

      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      bxr2_q <= bxr1_q;
      byr2_q <= byr1_q;
      cxr2_q <= cxr1_q;
      cyr2_q <= cyr1_q;
      d2_q   <= (D_W'(bxr1_q) * D_W'(cyr1_q) - D_W'(byr1_q) * D_W'(cxr1_q)) <<< 1;
      b2_q   <= (SQ_W+1)'(bxr1_q) * (SQ_W+1)'(bxr1_q) + (SQ_W+1)'(byr1_q) * (SQ_W+1)'(byr1_q);
      c2_q   <= (SQ_W+1)'(cxr1_q) * (SQ_W+1)'(cxr1_q) + (SQ_W+1)'(cyr1_q) * (SQ_W+1)'(cyr1_q);

      nx3_q  <= N_W'(cyr2_q) * N_W'(b2_q) - N_W'(byr2_q) * N_W'(c2_q);
      ny3_q  <= N_W'(bxr2_q) * N_W'(c2_q) - N_W'(cxr2_q) * N_W'(b2_q);
      adx3_q <= NUM_W'(ax2_q) * NUM_W'(d2_q);
      ady3_q <= NUM_W'(ay2_q) * NUM_W'(d2_q);
      d3_q   <= d2_q;

      numx4_q <= adx3_q + NUM_W'(nx3_q);
      numy4_q <= ady3_q + NUM_W'(ny3_q);
      mx4_q   <= nx3_q[N_W-1] ? N_W'(-nx3_q) : N_W'(nx3_q);
      my4_q   <= ny3_q[N_W-1] ? N_W'(-ny3_q) : N_W'(ny3_q);
      dmag4_q <= d3_q[D_W-1] ? D_W'(-d3_q) : D_W'(d3_q);
      sd4_q   <= d3_q[D_W-1];
      dz4_q   <= (d3_q == '0);

      mnx5_q  <= numx4_q[NUM_W-1] ? NUM_W'(-numx4_q) : NUM_W'(numx4_q);
      mny5_q  <= numy4_q[NUM_W-1] ? NUM_W'(-numy4_q) : NUM_W'(numy4_q);
      sx5_q   <= numx4_q[NUM_W-1] ^ sd4_q;
      sy5_q   <= numy4_q[NUM_W-1] ^ sd4_q;
      xll5_q  <= (2*HALF_W)'(xlo) * (2*HALF_W)'(xlo);
      xlh5_q  <= (HALF_W+HI_W)'(xlo) * (HALF_W+HI_W)'(xhi);
      xhh5_q  <= (2*HI_W)'(xhi) * (2*HI_W)'(xhi);
      yll5_q  <= (2*HALF_W)'(ylo) * (2*HALF_W)'(ylo);
      ylh5_q  <= (HALF_W+HI_W)'(ylo) * (HALF_W+HI_W)'(yhi);
      yhh5_q  <= (2*HI_W)'(yhi) * (2*HI_W)'(yhi);
      dmag5_q <= dmag4_q;
      dz5_q   <= dz4_q;

      // nx^2 + ny^2 from partial products, scaled for the fraction bits
      rad6_q  <= ((RAD_W'(xhh5_q) << (2*HALF_W)) + (RAD_W'(xlh5_q) << (HALF_W+1))
                 + RAD_W'(xll5_q) + (RAD_W'(yhh5_q) << (2*HALF_W))
                 + (RAD_W'(ylh5_q) << (HALF_W+1)) + RAD_W'(yll5_q)) << RAD_FRAC;
      mnx6_q  <= mnx5_q;
      mny6_q  <= mny5_q;
      sx6_q   <= sx5_q;
      sy6_q   <= sy5_q;
      dmag6_q <= dmag5_q;
      dz6_q   <= dz5_q;
    end
  end

  always_comb begin
    fr_o.v    = v_q[5];
    fr_o.dz   = dz6_q;
    fr_o.sx   = sx6_q;
    fr_o.sy   = sy6_q;
    fr_o.mnx  = mnx6_q;
    fr_o.mny  = mny6_q;
    fr_o.dmag = dmag6_q;
    fr_o.rad  = rad6_q;
  end

endmodule

// ----- rtl/ccp_sqrt.sv -----
// pipelined integer square root, two radicand bits per stage
// depends on ccp_pkg
module ccp_sqrt import ccp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  fr_t  fr_i,
  output sq_t  sq_o
);

  typedef struct packed {
    logic              dz;
    logic              sx;
    logic              sy;
    logic [NUM_W-1:0]  mnx;
    logic [NUM_W-1:0]  mny;
    logic [D_W-1:0]    dmag;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } rt_t;

  logic [ROOT_W-1:0] v_q;
  rt_t init;
  rt_t src  [ROOT_W];
  rt_t st_d [ROOT_W];
  rt_t st_q [ROOT_W];

  always_comb begin
    init      = '0;
    init.dz   = fr_i.dz;
    init.sx   = fr_i.sx;
    init.sy   = fr_i.sy;
    init.mnx  = fr_i.mnx;
    init.mny  = fr_i.mny;
    init.dmag = fr_i.dmag;
    init.rad  = fr_i.rad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ROOT_W-2:0], fr_i.v};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] r2, tr;

    if (k == 0) begin : g_first
      assign src[k] = init;
    end else begin : g_next
      assign src[k] = st_q[k-1];
    end

    assign r2 = {src[k].rem[REM_W-3:0], src[k].rad[RAD_W-1 -: 2]};
    assign tr = REM_W'({src[k].root, 2'b01});

    always_comb begin
      st_d[k]     = src[k];
      st_d[k].rad = src[k].rad << 2;
      if (r2 >= tr) begin
        st_d[k].rem  = r2 - tr;
        st_d[k].root = {src[k].root[ROOT_W-2:0], 1'b1};
      end else begin
        st_d[k].rem  = r2;
        st_d[k].root = {src[k].root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    sq_o.v    = v_q[ROOT_W-1];
    sq_o.dz   = st_q[ROOT_W-1].dz;
    sq_o.sx   = st_q[ROOT_W-1].sx;
    sq_o.sy   = st_q[ROOT_W-1].sy;
    sq_o.mnx  = st_q[ROOT_W-1].mnx;
    sq_o.mny  = st_q[ROOT_W-1].mny;
    sq_o.dmag = st_q[ROOT_W-1].dmag;
    sq_o.root = st_q[ROOT_W-1].root;
  end

endmodule

// ----- rtl/ccp_div.sv -----
// pipelined restoring divider, three lanes sharing one divisor, one bit per stage
// depends on ccp_pkg
module ccp_div import ccp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  sq_t  sq_i,
  output dv_t  dv_o
);

  typedef struct packed {
    logic                        dz;
    logic                        sx;
    logic                        sy;
    logic [D_W-1:0]              dmag;
    logic [NLANE-1:0][D_W-1:0]   rem;
    logic [NLANE-1:0][DVD_W-1:0] dvd;
  } ds_t;

  logic [DVD_W-1:0] v_q;
  ds_t init;
  ds_t src  [DVD_W];
  ds_t st_d [DVD_W];
  ds_t st_q [DVD_W];

  always_comb begin
    init            = '0;
    init.dz         = sq_i.dz;
    init.sx         = sq_i.sx;
    init.sy         = sq_i.sy;
    init.dmag       = sq_i.dmag;
    init.dvd[LN_X]  = DVD_W'(sq_i.mnx);
    init.dvd[LN_Y]  = DVD_W'(sq_i.mny);
    init.dvd[LN_R]  = sq_i.root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DVD_W-2:0], sq_i.v};
    end
  end

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = init;
    end else begin : g_next
      assign src[k] = st_q[k-1];
    end

    always_comb begin
      logic [D_W:0] r2, df;
      st_d[k] = src[k];
      for (int l = 0; l < NLANE; l++) begin
        r2 = {src[k].rem[l], src[k].dvd[l][DVD_W-1]};
        df = r2 - (D_W+1)'(src[k].dmag);
        if (r2 >= (D_W+1)'(src[k].dmag)) begin
          st_d[k].rem[l] = df[D_W-1:0];
          st_d[k].dvd[l] = {src[k].dvd[l][DVD_W-2:0], 1'b1};
        end else begin
          st_d[k].rem[l] = r2[D_W-1:0];
          st_d[k].dvd[l] = {src[k].dvd[l][DVD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    dv_o.v  = v_q[DVD_W-1];
    dv_o.dz = st_q[DVD_W-1].dz;
    dv_o.sx = st_q[DVD_W-1].sx;
    dv_o.sy = st_q[DVD_W-1].sy;
    dv_o.q  = st_q[DVD_W-1].dvd;
  end

endmodule

// ----- rtl/circumcircle_of_three_points.sv -----
// circumcircle of three points: front end, square root and divider pipelines, then an output register;
// one word accepted per cycle while the output is not held
// the whole pipeline advances together; it holds while a finished word waits
// asynchronous active-low reset clears all valid bits, payload is not reset
// depends on ccp_pkg, ccp_if, ccp_front, ccp_sqrt, ccp_div
module circumcircle_of_three_points import ccp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccp_pt_if.sink    pt_i,
  ccp_cc_if.source  cc_o
);

  // global pipeline enable: move whenever the output slot is free or being taken
  logic en;
  pt_t  pt;
  fr_t  fr;
  sq_t  sq;
  dv_t  dv;

  logic                    out_v_q;
  logic                    res_v_q;
  logic signed [OUT_W-1:0] ctr_x_q, ctr_y_q;
  logic        [OUT_W-1:0] rad_q;
  logic signed [OUT_W-1:0] ctr_x_d, ctr_y_d;
  logic        [OUT_W-1:0] rad_d;

  assign en         = !out_v_q || cc_o.ready;
  assign pt_i.ready = en;

  always_comb begin
    pt.ax       = pt_i.ax;
    pt.ay       = pt_i.ay;
    pt.bx       = pt_i.bx;
    pt.by_coord = pt_i.by_coord;
    pt.cx       = pt_i.cx;
    pt.cy       = pt_i.cy;
  end

  // denominator, numerators, magnitudes and the radius radicand
  ccp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (pt_i.valid),
    .pt_i   (pt),
    .fr_o   (fr)
  );

  // floor square root of 65536*(nx^2+ny^2)
  ccp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .fr_i   (fr),
    .sq_o   (sq)
  );

  // |num_x|/|d|, |num_y|/|d| and root/|d| in parallel lanes
  ccp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sq_i   (sq),
    .dv_o   (dv)
  );

  // sign and saturation; collinear points give all zeros
  always_comb begin
    if (dv.sx) begin
      ctr_x_d = (dv.q[LN_X] > DVD_W'(CTR_MIN)) ? CTR_MIN : -dv.q[LN_X][OUT_W-1:0];
    end else begin
      ctr_x_d = (dv.q[LN_X] > DVD_W'(CTR_MAX)) ? CTR_MAX : dv.q[LN_X][OUT_W-1:0];
    end
    if (dv.sy) begin
      ctr_y_d = (dv.q[LN_Y] > DVD_W'(CTR_MIN)) ? CTR_MIN : -dv.q[LN_Y][OUT_W-1:0];
    end else begin
      ctr_y_d = (dv.q[LN_Y] > DVD_W'(CTR_MAX)) ? CTR_MAX : dv.q[LN_Y][OUT_W-1:0];
    end
    rad_d = (dv.q[LN_R] > DVD_W'(RAD_MAX)) ? RAD_MAX : dv.q[LN_R][OUT_W-1:0];
    if (dv.dz) begin
      ctr_x_d = '0;
      ctr_y_d = '0;
      rad_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_v_q <= !dv.dz;
      ctr_x_q <= ctr_x_d;
      ctr_y_q <= ctr_y_d;
      rad_q   <= rad_d;
    end
  end

  assign cc_o.valid     = out_v_q;
  assign cc_o.valid_res = res_v_q;
  assign cc_o.center_x  = ctr_x_q;
  assign cc_o.center_y  = ctr_y_q;
  assign cc_o.radius    = rad_q;

`ifndef SYNTH
  // collinear result carries zero center and radius
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_o.valid && !cc_o.valid_res |->
      cc_o.center_x == '0 && cc_o.center_y == '0 && cc_o.radius == '0)
    else $error("collinear result with nonzero fields");

  // a true triangle has radius at least half a unit
  a_radius_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_o.valid && cc_o.valid_res |-> cc_o.radius != '0)
    else $error("valid circle with zero radius");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_i.ready |-> cc_o.valid && !cc_o.ready)
    else $error("input stalled without a waiting result");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for circumcircle_of_three_points: directed table, then random point triples
// results checked against typed answers or an exact integer circle predictor; depends on ccp_pkg, ccp_if and the top
module tb_top;
  import ccp_pkg::*;

  localparam int N_RAND    = 1530;
  localparam int END_WAIT  = 300;       // well past the pipeline depth
  localparam int CYC_LIMIT = 400000;

  // one expected circle, as the result channel carries it
  typedef struct {
    logic                    vld;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic        [OUT_W-1:0] r;
  } circle_t;

  // directed row: points, plus a typed answer where it is obvious
  typedef struct {
    pt_t     pts;
    logic    typed;
    circle_t ans;
  } row_t;

  logic clk;
  logic rst_n;

  ccp_pt_if pt ();
  ccp_cc_if cc ();

  circumcircle_of_three_points u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pt_i   (pt),
    .cc_o   (cc)
  );

  row_t    rows[$];         // every word to send, directed first
  circle_t circles_due[$];  // circles still owed by the pipeline
  int      sent;
  int      errors = 0;
  int      cycles = 0;
  int      tx_idle;
  int      rx_idle;

  // exact circumcircle in integers: center truncated toward zero, radius floor in Q24.8
  function automatic circle_t circle_of(pt_t p);
    circle_t      c;
    longint       ax, ay, bxr, byr, cxr, cyr, d, b2, c2, nx, ny, qx, qy;
    logic [191:0] wx, wy, rhs, dm, cw, t;
    logic [63:0]  r;
    ax  = longint'(p.ax);
    ay  = longint'(p.ay);
    bxr = longint'(p.bx) - ax;
    byr = longint'(p.by_coord) - ay;
    cxr = longint'(p.cx) - ax;
    cyr = longint'(p.cy) - ay;
    d   = 2 * (bxr * cyr - byr * cxr);
    c   = '{vld: 1'b0, x: '0, y: '0, r: '0};
    if (d == 0) return c;   // collinear: all zero
    b2 = bxr * bxr + byr * byr;
    c2 = cxr * cxr + cyr * cyr;
    nx = cyr * b2 - byr * c2;
    ny = bxr * c2 - cxr * b2;
    qx = (ax * d + nx) / d;   // signed division truncates toward zero
    qy = (ay * d + ny) / d;
    // clamp the center to the signed 32-bit range
    c.x = (qx > 64'sd2147483647) ? CTR_MAX : (qx < -64'sd2147483648) ? CTR_MIN : qx[31:0];
    c.y = (qy > 64'sd2147483647) ? CTR_MAX : (qy < -64'sd2147483648) ? CTR_MIN : qy[31:0];
    c.vld = 1'b1;
    wx  = {128'd0, (nx < 0) ? -nx : nx};
    wy  = {128'd0, (ny < 0) ? -ny : ny};
    dm  = {128'd0, (d < 0) ? -d : d};
    rhs = (wx * wx + wy * wy) << 16;
    // bitwise root search: largest r with (r*|d|)^2 <= 65536*(nx^2+ny^2)
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      cw = {128'd0, r | (64'd1 << b)};
      t  = cw * dm;
      if (t * t <= rhs) r = cw[63:0];
    end
    c.r = r[31:0];
    return c;
  endfunction

  function automatic pt_t pts_of(int ax, int ay, int bx, int by_c, int cx, int cy);
    pt_t p;
    p.ax       = COORD_BITS'(ax);
    p.ay       = COORD_BITS'(ay);
    p.bx       = COORD_BITS'(bx);
    p.by_coord = COORD_BITS'(by_c);
    p.cx       = COORD_BITS'(cx);
    p.cy       = COORD_BITS'(cy);
    return p;
  endfunction

  function automatic void add_row(pt_t p, logic typed, circle_t ans);
    rows.push_back('{pts: p, typed: typed, ans: ans});
  endfunction

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // directed table, then random triples
  initial begin
    circle_t zero, none;
    int      ax, ay, bx, by_c, k;
    zero = '{vld: 1'b0, x: '0, y: '0, r: '0};
    none = zero;
    // all points at the origin, repeated points, a straight line: collinear
    add_row(pts_of(0, 0, 0, 0, 0, 0), 1'b1, zero);
    add_row(pts_of(-32768, -32768, -32768, -32768, -32768, -32768), 1'b1, zero);
    add_row(pts_of(32767, 32767, 32767, 32767, 32767, 32767), 1'b1, zero);
    add_row(pts_of(-32768, -32768, 0, 0, 32767, 32767), 1'b0, none);
    add_row(pts_of(-32768, 5, 32767, 5, 100, 5), 1'b1, zero);
    add_row(pts_of(7, -32768, 7, 32767, 7, 0), 1'b1, zero);
    // small right triangles, read off by hand
    add_row(pts_of(0, 0, 2, 0, 0, 2), 1'b1, '{vld: 1'b1, x: 32'sd1, y: 32'sd1, r: 32'd362});
    add_row(pts_of(0, 0, 0, 2, 2, 0), 1'b1, '{vld: 1'b1, x: 32'sd1, y: 32'sd1, r: 32'd362});
    add_row(pts_of(0, 0, 1, 0, 0, 1), 1'b1, '{vld: 1'b1, x: 32'sd0, y: 32'sd0, r: 32'd181});
    add_row(pts_of(0, 0, -1, 0, 0, -1), 1'b1, '{vld: 1'b1, x: 32'sd0, y: 32'sd0, r: 32'd181});
    // corners of the coordinate range, both orientations
    add_row(pts_of(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0, none);
    add_row(pts_of(-32768, -32768, -32768, 32767, 32767, -32768), 1'b0, none);
    add_row(pts_of(32767, 32767, -32768, 32767, 32767, -32768), 1'b0, none);
    add_row(pts_of(-32768, 32767, 32767, 32767, 32767, -32768), 1'b0, none);
    // nearly collinear far apart and other mixed triangles; the radius can clamp
    add_row(pts_of(-32768, -32768, 32767, 32767, 32767, 32766), 1'b0, none);
    add_row(pts_of(-32768, -32768, 32767, 32766, 32767, 32767), 1'b0, none);
    add_row(pts_of(32767, -32768, -32768, 32767, -32768, 32766), 1'b0, none);
    add_row(pts_of(-32768, 32767, 32767, -32768, 32766, -32768), 1'b0, none);
    add_row(pts_of(-32768, 0, 32767, 1, 0, 0), 1'b0, none);
    add_row(pts_of(0, 0, 1, 0, 32767, 1), 1'b0, none);
    add_row(pts_of(-1, -1, 1, 1, 0, 1), 1'b0, none);
    for (int i = 0; i < N_RAND; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        // any triple over the full range
        add_row(pts_of($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                       $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                       $urandom_range(65535) - 32768, $urandom_range(65535) - 32768),
                1'b0, none);
      end else if (k < 70) begin
        // small coordinates around the origin
        add_row(pts_of(rnd_range(-8, 8), rnd_range(-8, 8), rnd_range(-8, 8),
                       rnd_range(-8, 8), rnd_range(-8, 8), rnd_range(-8, 8)), 1'b0, none);
      end else begin
        // near or exactly collinear: c = 2b - a + small offset
        ax   = rnd_range(-10000, 10000);
        ay   = rnd_range(-10000, 10000);
        bx   = rnd_range(-10000, 10000);
        by_c = rnd_range(-10000, 10000);
        add_row(pts_of(ax, ay, bx, by_c, 2 * bx - ax + rnd_range(-2, 2),
                       2 * by_c - ay + rnd_range(-2, 2)), 1'b0, none);
      end
    end
  end

  // sender: present the next word, unless randomly idle, whenever the last one went or none is up
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pt.valid    <= 1'b0;
      pt.ax       <= '0;
      pt.ay       <= '0;
      pt.bx       <= '0;
      pt.by_coord <= '0;
      pt.cx       <= '0;
      pt.cy       <= '0;
      sent        <= 0;
    end else begin
      int nxt;
      nxt = sent;
      if (pt.valid && pt.ready) begin
        circles_due.push_back(rows[sent].typed ? rows[sent].ans : circle_of(rows[sent].pts));
        nxt = sent + 1;
        sent <= nxt;
      end
      if (!pt.valid || pt.ready) begin
        if (nxt < rows.size() && $urandom_range(99) >= tx_idle) begin
          pt.valid    <= 1'b1;
          pt.ax       <= rows[nxt].pts.ax;
          pt.ay       <= rows[nxt].pts.ay;
          pt.bx       <= rows[nxt].pts.bx;
          pt.by_coord <= rows[nxt].pts.by_coord;
          pt.cx       <= rows[nxt].pts.cx;
          pt.cy       <= rows[nxt].pts.cy;
        end else begin
          pt.valid <= 1'b0;
        end
      end
    end
  end

  // idle mix follows progress through the words
  always_comb begin
    if (sent < rows.size() / 3) begin
      tx_idle = 8;
      rx_idle = 87;
    end else if (sent < 2 * rows.size() / 3) begin
      tx_idle = 87;
      rx_idle = 8;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  end

  // receiver: random backpressure, compare each word with the oldest circle due
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cc.ready <= 1'b0;
    end else begin
      cc.ready <= ($urandom_range(99) >= rx_idle);
      if (cc.valid && cc.ready) begin
        circle_t e;
        if (circles_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
        end else begin
          e = circles_due.pop_front();
          if (cc.valid_res !== e.vld || cc.center_x !== e.x || cc.center_y !== e.y ||
              cc.radius !== e.r) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp v=%0b x=%0d y=%0d r=%0d  got v=%0b x=%0d y=%0d r=%0d",
                       e.vld, e.x, e.y, e.r,
                       cc.valid_res, cc.center_x, cc.center_y, cc.radius);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // reset, then wait for the pipeline to drain
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (rows.size() == 0 || sent != rows.size() || circles_due.size() != 0)
      @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0 && circles_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
